### hdl/sem_pkg.sv
package sem_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_GRAD,
    ST_SQR,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef logic [23:0] pixel_t;
  typedef logic signed [11:0] grad_t;
  typedef logic [20:0] root_t;

  localparam int unsigned CHANNELS = 3;

  localparam logic [7:0] REG_WIDTH = 8'd0;
  localparam logic [7:0] REG_HEIGHT = 8'd1;

  localparam logic [10:0] WIDTH_RESET = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  localparam logic [7:0] MAG_CAP = 8'd255;
  // highest even power of two that can sit below a sum of two squares
  localparam root_t ROOT_START = 21'h100000;

endpackage

### hdl/sem_ram.sv
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/sobel_edge_magnitude_rgb.sv
// A result passes through line read, gradient, square, 11 root steps and output;
// a row-end second result follows once the first is taken (shift, gradient, square, root, output).
// One pixel at a time: in_stall holds off the next pixel until its results are taken,
// paced by per-channel bit-pair square roots run in lockstep (one result bit per cycle each).
// Reset: synchronous, clears counters, window and sets width 640, height 480;
// the two line memories are not cleared.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic        last_of_run,
  output logic        end_of_frame
);

  localparam int AW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] ONE_W = WW'(1);

  sem_pkg::state_t state, state_next;

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [AW-1:0] col;
  logic [12:0] row;

  logic [AW-1:0] c_q;
  logic last_q, drain_q, emit_a_q, emit_b_q, second;
  sem_pkg::pixel_t px_q;

  sem_pkg::pixel_t win [3][3];
  sem_pkg::grad_t gx [sem_pkg::CHANNELS];
  sem_pkg::grad_t gy [sem_pkg::CHANNELS];
  sem_pkg::root_t rem [sem_pkg::CHANNELS];
  sem_pkg::root_t res [sem_pkg::CHANNELS];
  sem_pkg::root_t bitv;

  logic [WW-1:0] w_raw, w, col_ext, c_eff_w;
  logic [12:0] h;
  logic [AW-1:0] c_eff;
  logic last_in, drain_in;
  sem_pkg::pixel_t px_in;
  sem_pkg::pixel_t upper_q, middle_q, top_px, mid_px;
  logic accept;

  sem_pkg::grad_t gx_c [sem_pkg::CHANNELS];
  sem_pkg::grad_t gy_c [sem_pkg::CHANNELS];
  sem_pkg::root_t sum_try [sem_pkg::CHANNELS];
  sem_pkg::root_t res_step [sem_pkg::CHANNELS];
  sem_pkg::root_t rem_step [sem_pkg::CHANNELS];
  logic [7:0] mag [sem_pkg::CHANNELS];

  function automatic sem_pkg::grad_t grad_t_of(sem_pkg::pixel_t p, int ch);
    logic [7:0] v;
    v = p[8*ch +: 8];
    return $signed({4'b0000, v});
  endfunction

  // effective geometry
  always_comb begin
    w_raw = WW'(image_width);
    if (w_raw == '0) begin
      w = ONE_W;
    end else if (w_raw > MAXW) begin
      w = MAXW;
    end else begin
      w = w_raw;
    end
    h = (image_height == '0) ? 13'd1 : image_height;
    col_ext = WW'(col);
    c_eff_w = (col_ext >= w) ? (w - ONE_W) : col_ext;
    c_eff = c_eff_w[AW-1:0];
    last_in = (c_eff_w == (w - ONE_W));
    drain_in = (row >= h);
    px_in = (drain_in || req_type) ? '0 : {in_red, in_green, in_blue};
  end

  assign accept = (state == sem_pkg::ST_IDLE) && in_valid;
  assign in_stall = (state != sem_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
    .clk  (clk),
    .we   (state == sem_pkg::ST_READ),
    .waddr(c_q),
    .wdata(mid_px),
    .raddr(c_eff),
    .rdata(upper_q)
  );

  sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
    .clk  (clk),
    .we   (state == sem_pkg::ST_READ),
    .waddr(c_q),
    .wdata(px_q),
    .raddr(c_eff),
    .rdata(middle_q)
  );

  assign top_px = (row >= 13'd2) ? upper_q : '0;
  assign mid_px = (row != '0) ? middle_q : '0;

  // gradients and root step, per channel
  always_comb begin
    for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
      gx_c[ch] = (grad_t_of(win[0][2], ch) - grad_t_of(win[0][0], ch))
               + ((grad_t_of(win[1][2], ch) - grad_t_of(win[1][0], ch)) <<< 1)
               + (grad_t_of(win[2][2], ch) - grad_t_of(win[2][0], ch));
      gy_c[ch] = (grad_t_of(win[2][0], ch) - grad_t_of(win[0][0], ch))
               + ((grad_t_of(win[2][1], ch) - grad_t_of(win[0][1], ch)) <<< 1)
               + (grad_t_of(win[2][2], ch) - grad_t_of(win[0][2], ch));
      sum_try[ch] = res[ch] + bitv;
      if (rem[ch] >= sum_try[ch]) begin
        rem_step[ch] = rem[ch] - sum_try[ch];
        res_step[ch] = (res[ch] >> 1) + bitv;
      end else begin
        rem_step[ch] = rem[ch];
        res_step[ch] = res[ch] >> 1;
      end
      mag[ch] = (res[ch] > 21'(sem_pkg::MAG_CAP)) ? sem_pkg::MAG_CAP : res[ch][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sem_pkg::ST_IDLE: begin
        if (in_valid) state_next = sem_pkg::ST_READ;
      end
      sem_pkg::ST_READ: begin
        if (emit_a_q) begin
          state_next = sem_pkg::ST_GRAD;
        end else if (emit_b_q) begin
          state_next = sem_pkg::ST_SHIFT;
        end else begin
          state_next = sem_pkg::ST_IDLE;
        end
      end
      sem_pkg::ST_SHIFT: state_next = sem_pkg::ST_GRAD;
      sem_pkg::ST_GRAD:  state_next = sem_pkg::ST_SQR;
      sem_pkg::ST_SQR:   state_next = sem_pkg::ST_ROOT;
      sem_pkg::ST_ROOT: begin
        if (bitv == 21'd1) state_next = sem_pkg::ST_OUT;
      end
      sem_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = (!second && emit_b_q) ? sem_pkg::ST_SHIFT : sem_pkg::ST_IDLE;
        end
      end
      default: state_next = sem_pkg::ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= sem_pkg::WIDTH_RESET;
      image_height <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == sem_pkg::REG_WIDTH) begin
        image_width <= cfg_data[10:0];
      end else if (cfg_index == sem_pkg::REG_HEIGHT) begin
        image_height <= cfg_data[12:0];
      end
    end
  end

  // counters, window and beat bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      second <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      if (state == sem_pkg::ST_READ) begin
        second <= 1'b0;
        if (last_q) begin
          col <= '0;
          row <= drain_q ? 13'd0 : row + 13'd1;
        end else begin
          col <= c_q + AW'(1);
        end
        for (int i = 0; i < 3; i++) begin
          win[i][0] <= (c_q == '0) ? '0 : win[i][1];
          win[i][1] <= (c_q == '0) ? '0 : win[i][2];
        end
        win[0][2] <= top_px;
        win[1][2] <= mid_px;
        win[2][2] <= px_q;
      end else if (state == sem_pkg::ST_SHIFT) begin
        second <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          win[i][0] <= win[i][1];
          win[i][1] <= win[i][2];
          win[i][2] <= '0;
        end
      end
    end
  end

  // captured item and arithmetic registers
  always_ff @(posedge clk) begin
    if (accept) begin
      c_q <= c_eff;
      last_q <= last_in;
      drain_q <= drain_in;
      px_q <= px_in;
      emit_a_q <= (row != '0) && (c_eff != '0);
      emit_b_q <= (row != '0) && last_in;
    end
    unique case (state)
      sem_pkg::ST_GRAD: begin
        for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
          gx[ch] <= gx_c[ch];
          gy[ch] <= gy_c[ch];
        end
      end
      sem_pkg::ST_SQR: begin
        for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
          rem[ch] <= 21'(gx[ch] * gx[ch]) + 21'(gy[ch] * gy[ch]);
          res[ch] <= '0;
        end
        bitv <= sem_pkg::ROOT_START;
      end
      sem_pkg::ST_ROOT: begin
        for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
          rem[ch] <= rem_step[ch];
          res[ch] <= res_step[ch];
        end
        bitv <= bitv >> 2;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = (state == sem_pkg::ST_OUT);
  assign out_blue = mag[0];
  assign out_green = mag[1];
  assign out_red = mag[2];
  assign last_of_run = second || !emit_b_q;
  assign end_of_frame = second && drain_q;

endmodule
